// File: rtl/lzfu_pkg.sv
// Shared types, constants and the dictionary prelude for the LZFu decompressor.
// No dependencies; imported by lzfu_ctrl, lzfu_dp and lzfu_rtf_decompressor_unit.
`default_nettype none

package lzfu_pkg;

  localparam int DICT_DEPTH     = 4096;
  localparam int DICT_AW        = $clog2(DICT_DEPTH);
  localparam int PRELUDE_LENGTH = 207;
  localparam int HDR_BYTES      = 16;

  localparam logic [31:0] MAGIC_LZFU = 32'h7546_5A4C;
  localparam logic [31:0] MAGIC_RAW  = 32'h414C_454D;

  localparam logic [31:0] SIZE_BIAS    = 32'd4;
  localparam logic [4:0]  REF_LEN_BIAS = 5'd2;
  localparam logic [3:0]  FLAGS_DONE   = 4'd8;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_SIZE  = 2'd2;
  localparam logic [1:0] ST_MAGIC = 2'd3;

  localparam logic [PRELUDE_LENGTH*8-1:0] PRELUDE_TEXT = {
    "{\\rtf1\\ansi\\mac\\deff0\\deftab720{\\fonttbl;}",
    "{\\f0\\fnil \\froman \\fswiss \\fmodern \\fscript ",
    "\\fdecor MS Sans SerifSymbolArialTimes New RomanCourier",
    "{\\colortbl\\red0\\green0\\blue0\015\012\\par ",
    "\\pard\\plain\\f0\\fs20\\b\\i\\u\\tab\\tx"
  };

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } lzfu_in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  out_byte;
    logic [1:0]  status;
    logic [31:0] out_count;
  } lzfu_out_t;

  typedef enum logic [2:0] {
    CLS_END,
    CLS_HDR,
    CLS_DROP,
    CLS_RAW,
    CLS_LIT,
    CLS_CTRL,
    CLS_REF1,
    CLS_REF2
  } lzfu_cls_t;

  typedef struct packed {
    logic latch_in;
    logic clr_wr;
    logic clr_job;
    logic upd;
    logic consume;
    logic emit_byte;
    logic emit_end;
    logic copy_start;
    logic copy_rd;
    logic copy_emit;
  } lzfu_cmd_t;

  typedef struct packed {
    lzfu_cls_t cls;
    logic      out_free;
    logic      clr_last;
    logic      copy_last;
  } lzfu_sts_t;

  function automatic logic [7:0] prelude_byte(input logic [DICT_AW-1:0] addr);
    logic [7:0] idx;
    logic [7:0] res;
    idx = 8'(PRELUDE_LENGTH - 1) - addr[7:0];
    res = 8'd0;
    if (addr < DICT_AW'(PRELUDE_LENGTH)) begin
      res = PRELUDE_TEXT[{idx, 3'b000} +: 8];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/lzfu_ctrl.sv
// Sequencing state machine of the LZFu decompressor: dictionary refill,
// item intake, per-item dispatch and back-reference copy. Uses lzfu_pkg.
`default_nettype none

module lzfu_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  lzfu_pkg::lzfu_sts_t sts,
  output lzfu_pkg::lzfu_cmd_t cmd
);
  import lzfu_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PROC,
    S_RD,
    S_WR
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_PROC;
        end
      end
      S_PROC: begin
        unique case (sts.cls) inside
          CLS_END: begin
            if (sts.out_free) begin
              cmd.emit_end = 1'b1;
              cmd.clr_job  = 1'b1;
              state_nxt    = S_CLEAR;
            end
          end
          CLS_HDR, CLS_CTRL, CLS_REF1: begin
            cmd.upd     = 1'b1;
            cmd.consume = 1'b1;
            state_nxt   = S_IDLE;
          end
          CLS_DROP: begin
            cmd.consume = 1'b1;
            state_nxt   = S_IDLE;
          end
          CLS_RAW, CLS_LIT: begin
            if (sts.out_free) begin
              cmd.emit_byte = 1'b1;
              cmd.consume   = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          CLS_REF2: begin
            cmd.copy_start = 1'b1;
            cmd.consume    = 1'b1;
            state_nxt      = S_RD;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_RD: begin
        cmd.copy_rd = 1'b1;
        state_nxt   = S_WR;
      end
      S_WR: begin
        if (sts.out_free) begin
          cmd.copy_emit = 1'b1;
          state_nxt     = sts.copy_last ? S_IDLE : S_RD;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

`ifndef SYNTHESIS
  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_byte || cmd.emit_end || cmd.copy_emit) |-> sts.out_free)
    else $error("result loaded while output register occupied");
  a_copy_rd_then_wr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.copy_rd |=> (state_r == S_WR))
    else $error("dictionary read not followed by copy write");
`endif

endmodule

`default_nettype wire

// File: rtl/lzfu_dp.sv
// Datapath of the LZFu decompressor: header fields, decode state, 4096-byte
// dictionary ring, copy engine and output register. Uses lzfu_pkg.
`default_nettype none

module lzfu_dp (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_wr_en,
  input  wire [31:0]          cfg_wr_data,
  input  lzfu_pkg::lzfu_in_t  in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output lzfu_pkg::lzfu_out_t out_data,
  input  lzfu_pkg::lzfu_cmd_t cmd,
  output lzfu_pkg::lzfu_sts_t sts
);
  import lzfu_pkg::*;

  logic [7:0]         ring_mem [DICT_DEPTH];
  logic [7:0]         rd_data_r;

  lzfu_in_t           in_r;
  lzfu_out_t          out_r;
  logic               out_valid_r;
  logic [31:0]        cfg_len_r;

  logic [DICT_AW-1:0] clr_addr_r;
  logic [DICT_AW-1:0] wp_r;
  logic [31:0]        rcv_r;
  logic [31:0]        cl_r;
  logic [31:0]        el_r;
  logic [31:0]        mg_r;
  logic [31:0]        prod_r;
  logic [7:0]         flag_r;
  logic [3:0]         fbi_r;
  logic [7:0]         ref1_r;
  logic               await_r;
  logic [1:0]         jst_r;
  logic [DICT_AW-1:0] copy_addr_r;
  logic [4:0]         copy_left_r;

  logic               hdr_phase;
  logic               past_end;
  logic               out_full;
  logic [1:0]         hdr_st;
  logic [1:0]         end_st;
  logic [4:0]         shift;
  lzfu_cls_t          cls;

  assign hdr_phase = (rcv_r[31:4] == '0);
  assign past_end  = ({1'b0, rcv_r} >= ({1'b0, cl_r} + {1'b0, SIZE_BIAS})) ||
                     (rcv_r >= cfg_len_r);
  assign out_full  = (prod_r >= el_r);
  assign end_st    = hdr_phase ? ST_SHORT : jst_r;
  assign shift     = {rcv_r[1:0], 3'b000};

  always_comb begin
    if (cfg_len_r < 32'(HDR_BYTES)) begin
      hdr_st = ST_SHORT;
    end else if (({1'b0, cl_r} + {1'b0, SIZE_BIAS}) > {1'b0, cfg_len_r}) begin
      hdr_st = ST_SIZE;
    end else if (mg_r != MAGIC_LZFU && mg_r != MAGIC_RAW) begin
      hdr_st = ST_MAGIC;
    end else begin
      hdr_st = ST_OK;
    end
  end

  always_comb begin
    if (in_r.op == OP_END) begin
      cls = CLS_END;
    end else if (hdr_phase) begin
      cls = CLS_HDR;
    end else if (jst_r != ST_OK || cfg_len_r < 32'(HDR_BYTES) || past_end || out_full) begin
      cls = CLS_DROP;
    end else if (mg_r == MAGIC_RAW) begin
      cls = CLS_RAW;
    end else if (await_r) begin
      cls = CLS_REF2;
    end else if (fbi_r[3]) begin
      cls = CLS_CTRL;
    end else if (!flag_r[fbi_r[2:0]]) begin
      cls = CLS_LIT;
    end else begin
      cls = CLS_REF1;
    end
  end

  assign sts.cls       = cls;
  assign sts.out_free  = !out_valid_r || !out_stall;
  assign sts.clr_last  = (clr_addr_r == DICT_AW'(DICT_DEPTH - 1));
  assign sts.copy_last = (copy_left_r == 5'd1) || ((prod_r + 32'd1) == el_r);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // dictionary write port: refill, literal, copied byte
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      ring_mem[clr_addr_r] <= prelude_byte(clr_addr_r);
    end else if (cmd.emit_byte && cls == CLS_LIT) begin
      ring_mem[wp_r] <= in_r.data_byte;
    end else if (cmd.copy_emit) begin
      ring_mem[wp_r] <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.copy_rd) begin
      rd_data_r <= ring_mem[copy_addr_r];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) in_r <= in_data;
    if (cmd.emit_byte) begin
      out_r <= '{kind: KIND_DATA, out_byte: in_r.data_byte, status: ST_OK, out_count: '0};
    end else if (cmd.emit_end) begin
      out_r <= '{kind: KIND_END, out_byte: 8'd0, status: end_st, out_count: prod_r};
    end else if (cmd.copy_emit) begin
      out_r <= '{kind: KIND_DATA, out_byte: rd_data_r, status: ST_OK, out_count: '0};
    end
    if (cmd.copy_start) begin
      copy_addr_r <= {ref1_r, in_r.data_byte[7:4]};
    end else if (cmd.copy_emit) begin
      copy_addr_r <= copy_addr_r + DICT_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cfg_len_r   <= '0;
      clr_addr_r  <= '0;
      copy_left_r <= '0;
      wp_r        <= DICT_AW'(PRELUDE_LENGTH);
      rcv_r       <= '0;
      cl_r        <= '0;
      el_r        <= '0;
      mg_r        <= '0;
      prod_r      <= '0;
      flag_r      <= '0;
      fbi_r       <= FLAGS_DONE;
      ref1_r      <= '0;
      await_r     <= 1'b0;
      jst_r       <= ST_OK;
    end else begin
      if (cfg_wr_en) cfg_len_r <= cfg_wr_data;

      if (cmd.emit_byte || cmd.emit_end || cmd.copy_emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cmd.clr_wr) clr_addr_r <= clr_addr_r + DICT_AW'(1);

      if (cmd.consume && rcv_r != '1) rcv_r <= rcv_r + 32'd1;

      if (cmd.upd) begin
        unique case (cls)
          CLS_HDR: begin
            unique case (rcv_r[3:2])
              2'd0:    cl_r[shift +: 8] <= in_r.data_byte;
              2'd1:    el_r[shift +: 8] <= in_r.data_byte;
              2'd2:    mg_r[shift +: 8] <= in_r.data_byte;
              default: ;
            endcase
            if (rcv_r[3:0] == 4'(HDR_BYTES - 1)) jst_r <= hdr_st;
          end
          CLS_CTRL: begin
            flag_r <= in_r.data_byte;
            fbi_r  <= '0;
          end
          CLS_REF1: begin
            ref1_r  <= in_r.data_byte;
            await_r <= 1'b1;
          end
          default: ;
        endcase
      end

      if (cmd.emit_byte) begin
        prod_r <= prod_r + 32'd1;
        if (cls == CLS_LIT) begin
          wp_r  <= wp_r + DICT_AW'(1);
          fbi_r <= fbi_r + 4'd1;
        end
      end

      if (cmd.copy_start) begin
        copy_left_r <= {1'b0, in_r.data_byte[3:0]} + REF_LEN_BIAS;
        await_r     <= 1'b0;
        fbi_r       <= fbi_r + 4'd1;
      end

      if (cmd.copy_emit) begin
        copy_left_r <= copy_left_r - 5'd1;
        wp_r        <= wp_r + DICT_AW'(1);
        prod_r      <= prod_r + 32'd1;
      end

      if (cmd.clr_job) begin
        wp_r    <= DICT_AW'(PRELUDE_LENGTH);
        rcv_r   <= '0;
        cl_r    <= '0;
        el_r    <= '0;
        mg_r    <= '0;
        prod_r  <= '0;
        flag_r  <= '0;
        fbi_r   <= FLAGS_DONE;
        ref1_r  <= '0;
        await_r <= 1'b0;
        jst_r   <= ST_OK;
      end
    end
  end

`ifndef SYNTHESIS
  a_prod_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    prod_r <= el_r)
    else $error("produced count passed the uncompressed size");
  a_fbi_range: assert property (@(posedge clk) disable iff (!rst_n)
    fbi_r <= FLAGS_DONE)
    else $error("flag bit index out of range");
  a_await_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    await_r |-> (fbi_r < FLAGS_DONE))
    else $error("reference pending outside a flag group");
`endif

endmodule

`default_nettype wire

// File: rtl/lzfu_rtf_decompressor_unit.sv
// Top level of the LZFu compressed-RTF decompressor.
// Instantiates lzfu_ctrl and lzfu_dp; uses lzfu_pkg.
`default_nettype none

// Accepts a compressed RTF blob one byte per transfer (16-byte header first),
// followed by an end item, and returns the decompressed bytes and then one end
// result with status and byte count. Each input item is taken in an intake step
// and then dispatched; an item that produces output waits while the output stalls.
// A back-reference produces its 2 to 17 bytes (fewer once the uncompressed size
// is reached), each read from the 4096-byte dictionary RAM and then emitted and
// written back at the ring pointer. After reset and after every end result the
// dictionary is refilled with the prelude and zeros, one entry per cycle, while
// input is stalled and configuration writes are still taken. input_length
// should be written between jobs.
module lzfu_rtf_decompressor_unit (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_wr_en,
  input  wire [31:0]          cfg_wr_data,
  input  wire                 in_valid,
  output logic                in_stall,
  input  lzfu_pkg::lzfu_in_t  in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output lzfu_pkg::lzfu_out_t out_data
);
  import lzfu_pkg::*;

  lzfu_cmd_t cmd;
  lzfu_sts_t sts;

  lzfu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzfu_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

`default_nettype wire

// File: sim/lzfu_rtf_decompressor_unit_chk.sv
`timescale 1ns / 1ps
// Scoreboard for lzfu_rtf_decompressor_unit: tracks input_length, decodes every input
// transfer into the results it must cause and compares the result channel in order.
// Depends on lzfu_pkg for the payload types and codes.
module lzfu_rtf_decompressor_unit_chk
  import lzfu_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        cfg_wr_en,
  input  wire [31:0] cfg_wr_data,
  input  wire        in_valid,
  input  wire        in_stall,
  input  lzfu_in_t   in_data,
  input  wire        out_valid,
  input  wire        out_stall,
  input  lzfu_out_t  out_data,
  output int         fail_count,
  output int         backlog
);

  logic [7:0]         ring [DICT_DEPTH];
  logic [DICT_AW-1:0] wr_ptr;
  logic [31:0]        len_reg;
  logic [31:0]        rx_count;
  logic [31:0]        csize;
  logic [31:0]        usize;
  logic [31:0]        magic;
  logic [31:0]        made;
  logic [7:0]         flags;
  logic [3:0]         flag_pos;
  logic [7:0]         ref_hi;
  logic               ref_wait;
  logic [1:0]         job_st;
  lzfu_out_t          decoded_q[$];
  lzfu_out_t          want;
  int                 results_seen = 0;

  task automatic report_mismatch(input string msg);
    if (fail_count < 100) $display("%0t ERROR %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want_v);
    if (got !== want_v)
      report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                results_seen, name, got, want_v));
  endtask

  task automatic reseed_ring();
    string seed;
    seed = "{\\rtf1\\ansi\\mac\\deff0\\deftab720{\\fonttbl;}";
    seed = {seed, "{\\f0\\fnil \\froman \\fswiss \\fmodern \\fscript "};
    seed = {seed, "\\fdecor MS Sans SerifSymbolArialTimes New RomanCourier"};
    seed = {seed, "{\\colortbl\\red0\\green0\\blue0\015\012\\par "};
    seed = {seed, "\\pard\\plain\\f0\\fs20\\b\\i\\u\\tab\\tx"};
    for (int i = 0; i < DICT_DEPTH; i++) ring[i] = (i < seed.len()) ? seed[i] : 8'h00;
    wr_ptr   = DICT_AW'(PRELUDE_LENGTH);
    rx_count = '0;
    csize    = '0;
    usize    = '0;
    magic    = '0;
    made     = '0;
    flags    = '0;
    flag_pos = FLAGS_DONE;
    ref_hi   = '0;
    ref_wait = 1'b0;
    job_st   = ST_OK;
  endtask

  task automatic push_data(input logic [7:0] b, input logic to_ring);
    lzfu_out_t r;
    r = '0;
    r.kind = KIND_DATA;
    r.out_byte = b;
    r.status = ST_OK;
    decoded_q.push_back(r);
    if (to_ring) begin
      ring[wr_ptr] = b;
      wr_ptr++;
    end
    made++;
  endtask

  task automatic decode_transfer(input lzfu_in_t it);
    lzfu_out_t          r;
    logic [31:0]        idx;
    logic [31:0]        plen;
    logic [7:0]         b;
    logic [DICT_AW-1:0] offset;
    int                 span;
    if (it.op == OP_END) begin
      r = '0;
      r.kind = KIND_END;
      r.status = (rx_count < HDR_BYTES) ? ST_SHORT : job_st;
      r.out_count = made;
      decoded_q.push_back(r);
      reseed_ring();
      return;
    end
    b = it.data_byte;
    idx = rx_count;
    if (rx_count != '1) rx_count++;
    if (idx < HDR_BYTES) begin
      case (idx[3:2])
        2'd0: csize[8*idx[1:0] +: 8] = b;
        2'd1: usize[8*idx[1:0] +: 8] = b;
        2'd2: magic[8*idx[1:0] +: 8] = b;
        default: ;
      endcase
      if (idx == HDR_BYTES - 1) begin
        if (len_reg < HDR_BYTES) job_st = ST_SHORT;
        else if ({1'b0, csize} + 33'd4 > {1'b0, len_reg}) job_st = ST_SIZE;
        else if (magic != MAGIC_LZFU && magic != MAGIC_RAW) job_st = ST_MAGIC;
        else job_st = ST_OK;
      end
      return;
    end
    if (job_st != ST_OK || len_reg < HDR_BYTES) return;
    plen = (csize >= 32'd12) ? csize - 32'd12 : '0;
    if (plen > len_reg - HDR_BYTES) plen = len_reg - HDR_BYTES;
    if (idx - HDR_BYTES >= plen || made >= usize) return;
    if (magic == MAGIC_RAW) begin
      push_data(b, 1'b0);
    end else if (ref_wait) begin
      offset = {ref_hi, b[7:4]};
      span = int'(b[3:0]) + 2;
      for (int k = 0; k < span && made < usize; k++) push_data(ring[DICT_AW'(offset + k)], 1'b1);
      ref_wait = 1'b0;
      flag_pos++;
    end else if (flag_pos >= FLAGS_DONE) begin
      flags = b;
      flag_pos = '0;
    end else if (!flags[flag_pos]) begin
      push_data(b, 1'b1);
      flag_pos++;
    end else begin
      ref_hi = b;
      ref_wait = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      len_reg = '0;
      reseed_ring();
      decoded_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing pending (kind %0d byte %02h)",
                                    results_seen, out_data.kind, out_data.out_byte));
        end else begin
          want = decoded_q.pop_front();
          check_field("kind", 32'(out_data.kind), 32'(want.kind));
          check_field("out_byte", 32'(out_data.out_byte), 32'(want.out_byte));
          check_field("status", 32'(out_data.status), 32'(want.status));
          check_field("out_count", out_data.out_count, want.out_count);
        end
      end
      if (in_valid && !in_stall) decode_transfer(in_data);
      if (cfg_wr_en) len_reg = cfg_wr_data;
    end
    backlog = decoded_q.size();
  end

endmodule

// File: sim/lzfu_rtf_decompressor_unit_tb.sv
`timescale 1ns / 1ps
// Top-level testbench for lzfu_rtf_decompressor_unit: builds compressed RTF jobs,
// drives them with random idling and gives the verdict.
// Depends on lzfu_pkg, the unit RTL and lzfu_rtf_decompressor_unit_chk.
module lzfu_rtf_decompressor_unit_tb;
  import lzfu_pkg::*;

  typedef enum int {
    JOB_LZFU,
    JOB_RAW,
    JOB_MAGIC,
    JOB_SIZE,
    JOB_SHORT,
    JOB_WIDE
  } job_kind_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  lzfu_in_t    in_data;
  logic        out_valid;
  logic        out_stall = 1'b0;
  lzfu_out_t   out_data;
  int          fail_count;
  int          backlog;

  bit          gaps_on = 1'b1;
  int          stall_left = 0;
  int          items_sent = 0;
  logic [7:0]  blob_q[$];
  logic [31:0] blob_len;

  always #1 clk = ~clk;

  lzfu_rtf_decompressor_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  lzfu_rtf_decompressor_unit_chk u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .backlog    (backlog)
  );

  always @(negedge clk) begin
    if (stall_left == 0 && gaps_on && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
    out_stall = (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  task automatic push_item(input logic op, input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = '{op: op, data_byte: b};
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) blob_q.push_back(w[8*i +: 8]);
  endtask

  task automatic wait_drained();
    while (backlog != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_job(input logic [31:0] len);
    wait_drained();
    cfg_wr_en = 1'b1;
    cfg_wr_data = len;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    foreach (blob_q[i]) push_item(OP_BYTE, blob_q[i]);
    push_item(OP_END, 8'($urandom));
    in_valid = 1'b0;
  endtask

  task automatic build_job(input job_kind_t kind);
    logic [7:0]  pay_q[$];
    logic [7:0]  ctl;
    logic [11:0] off;
    logic [31:0] csize;
    logic [31:0] usize;
    logic [31:0] magic;
    int          keep;
    blob_q.delete();
    if (kind == JOB_LZFU || kind == JOB_WIDE) begin
      repeat ($urandom_range(1, 2)) begin
        ctl = 8'($urandom);
        pay_q.push_back(ctl);
        for (int i = 0; i < 8; i++) begin
          if (ctl[i]) begin
            case ($urandom_range(0, 3))
              0, 1: off = 12'($urandom_range(0, PRELUDE_LENGTH - 1));
              2: off = 12'($urandom_range(PRELUDE_LENGTH, PRELUDE_LENGTH + 40));
              default: off = 12'($urandom);
            endcase
            pay_q.push_back(off[11:4]);
            pay_q.push_back({off[3:0], 4'($urandom)});
          end else begin
            pay_q.push_back(8'($urandom));
          end
        end
      end
      // cut anywhere, sometimes between the two bytes of a copy
      if ($urandom_range(0, 2) == 0) begin
        keep = $urandom_range(0, pay_q.size());
        while (pay_q.size() > keep) void'(pay_q.pop_back());
      end
    end else begin
      repeat ($urandom_range(0, kind == JOB_RAW ? 12 : 6)) pay_q.push_back(8'($urandom));
    end
    csize = 32'(pay_q.size()) + 32'd12;
    case ($urandom_range(0, 9))
      0: usize = '0;
      1, 2, 3: usize = $urandom_range(1, 40);
      4: usize = '1;
      default: usize = $urandom_range(100, 100000);
    endcase
    magic = (kind == JOB_RAW) ? MAGIC_RAW : MAGIC_LZFU;
    if (kind == JOB_RAW && $urandom_range(0, 3) == 0) csize = $urandom_range(0, 11);
    if (kind == JOB_LZFU || kind == JOB_RAW)
      repeat ($urandom_range(0, 2)) pay_q.push_back(8'($urandom));
    blob_len = 32'(pay_q.size()) + HDR_BYTES;
    case (kind)
      JOB_MAGIC: magic = ($urandom_range(0, 1) ? MAGIC_LZFU : MAGIC_RAW) ^ (32'h1 << $urandom_range(0, 31));
      JOB_SIZE: begin
        if ($urandom_range(0, 1)) begin
          csize = '1;
          blob_len = '1;
        end else begin
          csize = blob_len - 32'd4 + $urandom_range(1, 1000);
        end
      end
      JOB_WIDE: blob_len = '1;
      JOB_SHORT: if ($urandom_range(0, 1)) blob_len = $urandom_range(0, HDR_BYTES - 1);
      default: ;
    endcase
    put_word(csize);
    put_word(usize);
    put_word(magic);
    put_word($urandom);
    foreach (pay_q[i]) blob_q.push_back(pay_q[i]);
    if (kind == JOB_SHORT && blob_len >= HDR_BYTES) begin
      keep = $urandom_range(0, HDR_BYTES - 1);
      while (blob_q.size() > keep) void'(blob_q.pop_back());
    end
  endtask

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    job_kind_t  kind;
    int         rand_base;
    int         j;
    logic [7:0] dir_pay [10] = '{8'h3C, 8'h00, 8'hFF, 8'h00, 8'h0F,
                                 8'h0C, 8'hF0, 8'hFF, 8'hF3, 8'h12};
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // end of input with no bytes at all
    blob_q.delete();
    run_job(32'd0);

    // literals 00/FF, longest copy from the prelude, copy of fresh output,
    // copy across the ring end, then a copy that never gets its second byte
    blob_q.delete();
    put_word(32'd22);
    put_word('1);
    put_word(MAGIC_LZFU);
    put_word('0);
    foreach (dir_pay[i]) blob_q.push_back(dir_pay[i]);
    run_job(32'd26);

    rand_base = items_sent;
    for (j = 0; items_sent - rand_base < 150; j++) begin
      if (j < 6) begin
        kind = job_kind_t'(j);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: kind = JOB_LZFU;
          5, 6: kind = JOB_RAW;
          7: kind = JOB_MAGIC;
          8: kind = JOB_SIZE;
          default: kind = $urandom_range(0, 1) ? JOB_SHORT : JOB_WIDE;
        endcase
      end
      gaps_on = (items_sent - rand_base > 110) ? 1'b0 : ($urandom_range(0, 4) != 0);
      build_job(kind);
      run_job(blob_len);
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (fail_count == 0 && backlog == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
